### hw/rtl/mcr_pkg.sv
`default_nettype none

package mcr_pkg;

  // Command codes on the request channel
  localparam logic CmdStart = 1'b0;
  localparam logic CmdStep  = 1'b1;

  // Index of the final result of a step, per mode
  localparam logic [2:0] LastOutline = 3'd7;
  localparam logic [2:0] LastFill    = 3'd3;

  // Job queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = 1;
  localparam int QCntW      = 2;

  typedef logic signed [13:0] coord_t;

  // One octant step (or a finish marker) handed to the back end
  typedef struct packed {
    logic        finish;
    logic        fill;
    logic [11:0] cx;
    logic [11:0] cy;
    logic [10:0] ox;
    logic [10:0] oy;
    logic [31:0] color;
  } job_t;

endpackage

`default_nettype wire

### hw/rtl/mcr_front.sv
`default_nettype none

module mcr_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic          command_i,
  input  wire logic [11:0]   center_x_i,
  input  wire logic [11:0]   center_y_i,
  input  wire logic [10:0]   radius_i,
  input  wire logic          filled_i,
  input  wire logic [31:0]   color_i,
  input  wire logic          full_i,
  output logic               push_o,
  output mcr_pkg::job_t      push_job_o
);

  logic [10:0]        ox_q, ox_d;
  logic [10:0]        oy_q, oy_d;
  logic signed [15:0] dec_q, dec_d;
  logic [11:0]        cx_q, cx_d;
  logic [11:0]        cy_q, cy_d;
  logic               fill_q, fill_d;
  logic [31:0]        color_q, color_d;
  logic               active_q, active_d;

  logic               accept;
  logic               done;
  logic               dec_nonpos;
  logic [11:0]        y_new;
  logic [10:0]        x_new;
  logic signed [15:0] y_new_s;
  logic signed [15:0] x_new_s;
  logic signed [15:0] dec_inc;

  // Start requests need no queue space, but the stall stays payload-free
  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;

  // Octant exhausted or no circle loaded: this step only finishes
  assign done = ~active_q | (oy_q > ox_q);

  // Midpoint decision update
  assign dec_nonpos = dec_q[15] | (dec_q == 16'sd0);
  assign y_new      = {1'b0, oy_q} + 12'd1;
  assign x_new      = (dec_nonpos || ox_q == 11'd0) ? ox_q : ox_q - 11'd1;
  assign y_new_s    = signed'({4'b0, y_new});
  assign x_new_s    = signed'({5'b0, x_new});
  assign dec_inc    = dec_nonpos ? (y_new_s <<< 1) + 16'sd1
                                 : ((y_new_s - x_new_s) <<< 1) + 16'sd1;

  // Job snapshot taken before the state moves on
  assign push_o = accept & (command_i == mcr_pkg::CmdStep);
  always_comb begin
    push_job_o.finish = done;
    push_job_o.fill   = fill_q;
    push_job_o.cx     = cx_q;
    push_job_o.cy     = cy_q;
    push_job_o.ox     = ox_q;
    push_job_o.oy     = oy_q;
    push_job_o.color  = color_q;
  end

  // Circle state next value
  always_comb begin
    ox_d     = ox_q;
    oy_d     = oy_q;
    dec_d    = dec_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    fill_d   = fill_q;
    color_d  = color_q;
    active_d = active_q;
    if (accept) begin
      if (command_i == mcr_pkg::CmdStart) begin
        cx_d     = center_x_i;
        cy_d     = center_y_i;
        fill_d   = filled_i;
        color_d  = color_i;
        ox_d     = radius_i;
        oy_d     = 11'd0;
        dec_d    = 16'sd1 - signed'({5'b0, radius_i});
        active_d = 1'b1;
      end else if (done) begin
        active_d = 1'b0;
      end else begin
        oy_d  = y_new[10:0];
        ox_d  = x_new;
        dec_d = dec_q + dec_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q     <= '0;
      oy_q     <= '0;
      dec_q    <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      fill_q   <= 1'b0;
      color_q  <= '0;
      active_q <= 1'b0;
    end else begin
      ox_q     <= ox_d;
      oy_q     <= oy_d;
      dec_q    <= dec_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      fill_q   <= fill_d;
      color_q  <= color_d;
      active_q <= active_d;
    end
  end

  // A finishing step always drops the active flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && push_job_o.finish) |=> !active_q)
    else $error("active flag survived a finishing step");

endmodule

`default_nettype wire

### hw/rtl/mcr_queue.sv
`default_nettype none

module mcr_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire mcr_pkg::job_t  push_job_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                avail_o,
  output mcr_pkg::job_t       head_o
);

  mcr_pkg::job_t                  entry_q [mcr_pkg::QueueDepth];
  logic [mcr_pkg::QPtrW-1:0]      wr_q, rd_q;
  logic [mcr_pkg::QCntW-1:0]      cnt_q;

  assign full_o  = (cnt_q == mcr_pkg::QCntW'(mcr_pkg::QueueDepth));
  assign avail_o = (cnt_q != '0);
  assign head_o  = entry_q[rd_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= push_job_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + mcr_pkg::QCntW'(push_i) - mcr_pkg::QCntW'(pop_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full job queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> avail_o)
    else $error("pop from empty job queue");

endmodule

`default_nettype wire

### hw/rtl/mcr_back.sv
`default_nettype none

module mcr_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            avail_i,
  input  wire mcr_pkg::job_t   job_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output mcr_pkg::coord_t      span_left_x_o,
  output mcr_pkg::coord_t      span_right_x_o,
  output mcr_pkg::coord_t      row_y_o,
  output logic [31:0]          pixel_color_o,
  output logic                 finished_o,
  output logic                 last_o
);

  logic [2:0]       idx_q, idx_d;
  logic             vld_q, vld_d;
  mcr_pkg::coord_t  lx_q, rx_q, ry_q;
  logic [31:0]      col_q;
  logic             fin_q, lst_q;

  logic             load;
  logic             is_last;
  mcr_pkg::coord_t  lx, rx, ry;
  logic [13:0]      cx, cy, xo, yo;
  logic [13:0]      cxmx, cxpx, cxmy, cxpy, cymy, cypy, cymx, cypx;

  // Output register refills when empty or when its result is taken
  assign load = ~vld_q | ~out_stall_i;

  // Candidate coordinates of the current step
  assign cx   = {2'b0, job_i.cx};
  assign cy   = {2'b0, job_i.cy};
  assign xo   = {3'b0, job_i.ox};
  assign yo   = {3'b0, job_i.oy};
  assign cxmx = cx - xo;
  assign cxpx = cx + xo;
  assign cxmy = cx - yo;
  assign cxpy = cx + yo;
  assign cymy = cy - yo;
  assign cypy = cy + yo;
  assign cymx = cy - xo;
  assign cypx = cy + xo;

  // Select the result for the current index
  always_comb begin
    lx = '0;
    rx = '0;
    ry = '0;
    if (job_i.finish) begin
      is_last = 1'b1;
    end else if (job_i.fill) begin
      is_last = (idx_q == mcr_pkg::LastFill);
      case (idx_q[1:0])
        2'd0: begin lx = signed'(cxmx); rx = signed'(cxpx); ry = signed'(cymy); end
        2'd1: begin lx = signed'(cxmx); rx = signed'(cxpx); ry = signed'(cypy); end
        2'd2: begin lx = signed'(cxmy); rx = signed'(cxpy); ry = signed'(cymx); end
        default: begin lx = signed'(cxmy); rx = signed'(cxpy); ry = signed'(cypx); end
      endcase
    end else begin
      is_last = (idx_q == mcr_pkg::LastOutline);
      case (idx_q)
        3'd0: begin lx = signed'(cxmx); ry = signed'(cymy); end
        3'd1: begin lx = signed'(cxpx); ry = signed'(cymy); end
        3'd2: begin lx = signed'(cxmx); ry = signed'(cypy); end
        3'd3: begin lx = signed'(cxpx); ry = signed'(cypy); end
        3'd4: begin lx = signed'(cxmy); ry = signed'(cymx); end
        3'd5: begin lx = signed'(cxpy); ry = signed'(cymx); end
        3'd6: begin lx = signed'(cxmy); ry = signed'(cypx); end
        default: begin lx = signed'(cxpy); ry = signed'(cypx); end
      endcase
      rx = lx;
    end
  end

  // Sequencer: one result per cycle while the output is not stalled, pop on the last one
  assign pop_o = load & avail_i & is_last;
  always_comb begin
    idx_d = idx_q;
    vld_d = vld_q;
    if (load) begin
      vld_d = avail_i;
      if (avail_i) begin
        idx_d = is_last ? 3'd0 : idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load && avail_i) begin
      lx_q  <= lx;
      rx_q  <= rx;
      ry_q  <= ry;
      col_q <= job_i.color;
      fin_q <= job_i.finish;
      lst_q <= is_last;
    end
  end

  assign out_valid_o    = vld_q;
  assign span_left_x_o  = lx_q;
  assign span_right_x_o = rx_q;
  assign row_y_o        = ry_q;
  assign pixel_color_o  = col_q;
  assign finished_o     = fin_q;
  assign last_o         = lst_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && fin_q) |-> (lst_q && lx_q == '0 && rx_q == '0 && ry_q == '0))
    else $error("finish result carries coordinates or lacks last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (avail_i && job_i.fill && !job_i.finish) |-> (idx_q <= mcr_pkg::LastFill))
    else $error("span index ran past the fourth span");

endmodule

`default_nettype wire

### hw/rtl/midpoint_circle_rasterizer_unit.sv
// Midpoint circle rasterizer.
// Request channel: in_valid_i / in_stall_o with command_i and the circle
// fields. A start request (command 0) loads centre, radius, mode and color
// and produces nothing. Each step request (command 1) produces eight outline
// points or four horizontal spans of one octant step; a step after the octant
// is exhausted (or with no circle loaded) produces one finished result.
// Result channel: out_valid_o / out_stall_i, one result per cycle while
// out_stall_i is low, last_o on the final result of each step request.
// The first result of a step is registered in the job queue and then in
// the output register. The single output register gives one result per
// cycle while out_stall_i is low.
// A two-entry job queue between the front (circle state) and the back
// (result sequencer) lets requests be taken while results still drain.
// Reset clears the circle state, the queue and the output valid.
// While out_stall_i is high the result holds; the queue fills and then
// in_stall_o rises.
`default_nettype none

module midpoint_circle_rasterizer_unit (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             command_i,
  input  wire logic [11:0]      center_x_i,
  input  wire logic [11:0]      center_y_i,
  input  wire logic [10:0]      radius_i,
  input  wire logic             filled_i,
  input  wire logic [31:0]      color_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output mcr_pkg::coord_t       span_left_x_o,
  output mcr_pkg::coord_t       span_right_x_o,
  output mcr_pkg::coord_t       row_y_o,
  output logic [31:0]           pixel_color_o,
  output logic                  finished_o,
  output logic                  last_o
);

  logic          full;
  logic          push;
  mcr_pkg::job_t push_job;
  logic          pop;
  logic          avail;
  mcr_pkg::job_t head;

  mcr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .radius_i   (radius_i),
    .filled_i   (filled_i),
    .color_i    (color_i),
    .full_i     (full),
    .push_o     (push),
    .push_job_o (push_job)
  );

  mcr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .avail_o    (avail),
    .head_o     (head)
  );

  mcr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .avail_i        (avail),
    .job_i          (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .span_left_x_o  (span_left_x_o),
    .span_right_x_o (span_right_x_o),
    .row_y_o        (row_y_o),
    .pixel_color_o  (pixel_color_o),
    .finished_o     (finished_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire
